// ===== src/gbba_pkg.sv =====
// Shared types and constants of the grouped bitmap block allocator.
// Used by gbba_core and grouped_bitmap_block_allocator; no dependencies.
`timescale 1ns / 1ps

package gbba_pkg;

  localparam int ID_W   = 14;
  localparam int ST_W   = 2;
  localparam int CFG_W  = 4;
  localparam int WORD_W = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam int GROUPS_DEF           = 8;
  localparam int DATA_PER_GROUP_DEF   = 1024;
  localparam int BLOCKS_PER_GROUP_DEF = 1056;

  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_OCCUPY = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] blk_num;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] alloc_id;
    logic [ST_W-1:0] status;
  } out_item_t;

endpackage

// ===== src/gbba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gbba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gbba_core.sv =====
// Allocator sequencer: clearing pass, first-fit word scan, group divider for
// occupy, and read-modify-write of the bitmap RAM. Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_core #(
  parameter int GROUPS           = gbba_pkg::GROUPS_DEF,
  parameter int DATA_PER_GROUP   = gbba_pkg::DATA_PER_GROUP_DEF,
  parameter int BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF,
  parameter int WPG              = (DATA_PER_GROUP + 63) / 64,
  parameter int TOTAL_WORDS      = GROUPS * WPG,
  parameter int ADDR_W           = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbba_pkg::CFG_W-1:0]    groups_in_use,
  input  logic                          in_valid,
  input  gbba_pkg::in_item_t            in_data,
  output logic                          in_stall,
  output logic                          res_valid,
  output gbba_pkg::out_item_t           res_data,
  input  logic                          res_take,
  output logic                          ram_we,
  output logic [ADDR_W-1:0]             ram_waddr,
  output logic [gbba_pkg::WORD_W-1:0]   ram_wdata,
  output logic [ADDR_W-1:0]             ram_raddr,
  input  logic [gbba_pkg::WORD_W-1:0]   ram_rdata
);

  localparam int META    = BLOCKS_PER_GROUP - DATA_PER_GROUP;
  localparam int WIG_W   = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int GRP_W   = $clog2(GROUPS + 1);
  localparam int CMP_W   = (GRP_W > gbba_pkg::CFG_W) ? GRP_W : gbba_pkg::CFG_W;
  localparam int IDC_RAW = $clog2((GROUPS + 1) * BLOCKS_PER_GROUP + 2);
  localparam int IDC_W   = (IDC_RAW > gbba_pkg::ID_W) ? IDC_RAW : gbba_pkg::ID_W;
  localparam int LAST_BITS = DATA_PER_GROUP - (WPG - 1) * 64;
  localparam logic [gbba_pkg::WORD_W-1:0] LAST_MASK =
    (LAST_BITS >= 64) ? {gbba_pkg::WORD_W{1'b1}}
                      : ((gbba_pkg::WORD_W'(1) << LAST_BITS) - gbba_pkg::WORD_W'(1));

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_DIV  = 6'b001000,
    S_OWR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic [WIG_W-1:0]        wig_r, wig_nxt;
  logic [GRP_W-1:0]        grp_r, grp_nxt;
  logic [IDC_W-1:0]        gbase_r, gbase_nxt;
  logic [IDC_W-1:0]        rem_r, rem_nxt;
  logic [5:0]              bit_r, bit_nxt;
  gbba_pkg::out_item_t     res_r, res_nxt;

  logic [GRP_W-1:0]            eff;
  logic [CMP_W-1:0]            cfg_ext;
  logic [gbba_pkg::WORD_W-1:0] free_bits;
  logic [gbba_pkg::WORD_W-1:0] lowest;
  logic [5:0]                  bidx;
  logic [IDC_W-1:0]            data_bit;
  logic                        last_word;

  // Groups beyond the built size act as the built size.
  always_comb begin
    cfg_ext = CMP_W'(groups_in_use);
    if (cfg_ext > CMP_W'(GROUPS)) begin
      eff = GRP_W'(GROUPS);
    end else begin
      eff = GRP_W'(cfg_ext);
    end
  end

  always_comb begin
    free_bits = ~ram_rdata;
    if (wig_r == WIG_W'(WPG - 1)) begin
      free_bits = free_bits & LAST_MASK;
    end
    lowest = free_bits & (~free_bits + gbba_pkg::WORD_W'(1));
    bidx = '0;
    for (int i = 0; i < gbba_pkg::WORD_W; i++) begin
      if (lowest[i]) begin
        bidx = bidx | 6'(i);
      end
    end
  end

  assign last_word = (wig_r == WIG_W'(WPG - 1)) && ((grp_r + GRP_W'(1)) == eff);
  assign data_bit  = rem_r - IDC_W'(META);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    wig_nxt   = wig_r;
    grp_nxt   = grp_r;
    gbase_nxt = gbase_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    case (state_r)
      S_CLR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + ADDR_W'(1);
        if (addr_r == ADDR_W'(TOTAL_WORDS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.alloc_id = '0;
          grp_nxt          = '0;
          addr_nxt         = '0;
          wig_nxt          = '0;
          if (in_data.req_type == gbba_pkg::REQ_ALLOC) begin
            gbase_nxt = IDC_W'(META + 1);
            if (eff == '0) begin
              res_nxt.status = gbba_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (in_data.blk_num == '0) begin
            res_nxt.status = gbba_pkg::ST_INVALID;
            state_nxt      = S_DONE;
          end else begin
            rem_nxt   = IDC_W'(in_data.blk_num) - IDC_W'(1);
            state_nxt = S_DIV;
          end
        end
      end
      S_SCAN: begin
        // The read data belongs to the word at addr_r; the next word is
        // requested in the same cycle so the scan runs one word per cycle.
        if (free_bits != '0) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata | lowest;
          res_nxt.alloc_id = gbba_pkg::ID_W'(gbase_r + (IDC_W'(wig_r) << 6)
                                             + IDC_W'(bidx));
          res_nxt.status   = gbba_pkg::ST_OK;
          state_nxt        = S_DONE;
        end else if (last_word) begin
          res_nxt.alloc_id = '0;
          res_nxt.status   = gbba_pkg::ST_FULL;
          state_nxt        = S_DONE;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
          if (wig_r == WIG_W'(WPG - 1)) begin
            wig_nxt   = '0;
            grp_nxt   = grp_r + GRP_W'(1);
            gbase_nxt = gbase_r + IDC_W'(BLOCKS_PER_GROUP);
          end else begin
            wig_nxt = wig_r + WIG_W'(1);
          end
        end
      end
      S_DIV: begin
        // One group is subtracted per cycle; addr_r tracks the group's first word.
        if (grp_r == eff) begin
          res_nxt.status = gbba_pkg::ST_INVALID;
          state_nxt      = S_DONE;
        end else if (rem_r >= IDC_W'(BLOCKS_PER_GROUP)) begin
          rem_nxt  = rem_r - IDC_W'(BLOCKS_PER_GROUP);
          grp_nxt  = grp_r + GRP_W'(1);
          addr_nxt = addr_r + ADDR_W'(WPG);
        end else if (rem_r < IDC_W'(META)) begin
          res_nxt.status = gbba_pkg::ST_INVALID;
          state_nxt      = S_DONE;
        end else begin
          addr_nxt  = addr_r + ADDR_W'(data_bit >> 6);
          bit_nxt   = data_bit[5:0];
          state_nxt = S_OWR;
        end
      end
      S_OWR: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata | (gbba_pkg::WORD_W'(1) << bit_r);
        res_nxt.status = gbba_pkg::ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_raddr = addr_nxt;
  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wig_r   <= wig_nxt;
    grp_r   <= grp_nxt;
    gbase_r <= gbase_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== src/grouped_bitmap_block_allocator.sv =====
// Allocate: the first-fit scan reads the bitmap at one RAM word per cycle; occupy: the
//   divider steps through the groups one at a time. One request is in work at a time;
//   the next input transfer can be taken once the result reaches the output register.
// Reset starts a clearing pass over all GROUPS * ceil(DATA/64) bitmap words (128 by default)
//   with in_stall high; cfg writes are taken. Depends on gbba_pkg, gbba_ram and gbba_core.
`timescale 1ns / 1ps

module grouped_bitmap_block_allocator #(
  parameter int GROUPS           = gbba_pkg::GROUPS_DEF,
  parameter int DATA_PER_GROUP   = gbba_pkg::DATA_PER_GROUP_DEF,
  parameter int BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [gbba_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  input  gbba_pkg::in_item_t         in_data,
  output logic                       in_stall,
  output logic                       out_valid,
  output gbba_pkg::out_item_t        out_data,
  input  logic                       out_stall
);

  localparam int WPG         = (DATA_PER_GROUP + 63) / 64;
  localparam int TOTAL_WORDS = GROUPS * WPG;
  localparam int ADDR_W      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;

  logic [gbba_pkg::CFG_W-1:0]  groups_r;
  logic                        out_valid_r, out_valid_nxt;
  gbba_pkg::out_item_t         out_data_r;
  logic                        res_valid;
  gbba_pkg::out_item_t         res_data;
  logic                        res_take;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [gbba_pkg::WORD_W-1:0] ram_wdata;
  logic [gbba_pkg::WORD_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_r <= gbba_pkg::CFG_RESET;
    end else if (cfg_we) begin
      groups_r <= cfg_wdata;
    end
  end

  // The output register frees the core as soon as it holds the result.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gbba_ram #(
    .WIDTH (gbba_pkg::WORD_W),
    .DEPTH (TOTAL_WORDS),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbba_core #(
    .GROUPS           (GROUPS),
    .DATA_PER_GROUP   (DATA_PER_GROUP),
    .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP),
    .WPG              (WPG),
    .TOTAL_WORDS      (TOTAL_WORDS),
    .ADDR_W           (ADDR_W)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .groups_in_use (groups_r),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .res_valid     (res_valid),
    .res_data      (res_data),
    .res_take      (res_take),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

`ifndef SYNTHESIS
  // Reset always starts the clearing pass, so no transfer is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // A request transfer always leaves the core busy in the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core idle right after a transfer");

  // A result handed to the output register is shown in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid && (out_data == $past(res_data))))
    else $error("result lost on the way to the output register");
`endif

endmodule
